/* rtl/go_back_n_arq_endpoint_defines.svh */
// Assertion macros used by the go-back-N endpoint back end.
`ifndef GO_BACK_N_ARQ_ENDPOINT_DEFINES_SVH
`define GO_BACK_N_ARQ_ENDPOINT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GBN_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("go-back-N endpoint check failed");

// Next-cycle implication, checked out of reset.
`define GBN_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("go-back-N endpoint check failed");

`endif

/* rtl/gbn_pkg.sv */
// Types, codes and helpers shared by the go-back-N endpoint modules.
`timescale 1ns / 1ps

package gbn_pkg;

  // Field widths of the stream items
  localparam int PAYLOAD_BITS = 24;
  localparam int FLD_SEQ_W    = 3;
  localparam int FLD_KIND_W   = 2;
  localparam int FLD_ACT_W    = 2;

  // Largest sequence number supported and default window
  localparam int MAX_SEQ_DEF  = 7;
  localparam int SEQ_CAP_W    = 6;

  // Depth of the front-to-back queue
  localparam int QUEUE_DEPTH  = 2;

  // Input tdata layout: payload, rx_seq, rx_ack, rx_payload
  localparam int IN_PAY_LSB    = 0;
  localparam int IN_RSEQ_LSB   = IN_PAY_LSB + PAYLOAD_BITS;
  localparam int IN_RACK_LSB   = IN_RSEQ_LSB + FLD_SEQ_W;
  localparam int IN_RPAY_LSB   = IN_RACK_LSB + FLD_SEQ_W;
  localparam int IN_FIELDS_W   = IN_RPAY_LSB + PAYLOAD_BITS;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata layout: seq, ack, data_out, outstanding, window_open
  localparam int OUT_FIELDS_W  = 3 * FLD_SEQ_W + PAYLOAD_BITS + 1;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Input action codes
  localparam logic [FLD_ACT_W-1:0] ACT_SEND    = 2'd0;
  localparam logic [FLD_ACT_W-1:0] ACT_ARRIVE  = 2'd1;
  localparam logic [FLD_ACT_W-1:0] ACT_CKSUM   = 2'd2;
  localparam logic [FLD_ACT_W-1:0] ACT_TIMEOUT = 2'd3;

  // Work queued for the back end
  typedef enum logic [1:0] {
    OP_SEND,
    OP_ARRIVE,
    OP_TIMEOUT
  } gbn_op_t;

  // Result kinds
  typedef enum logic [FLD_KIND_W-1:0] {
    KIND_SENT,
    KIND_DELIVERED,
    KIND_DROPPED,
    KIND_REFUSED
  } gbn_kind_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_RPL_WAIT,
    ST_RPL_OUT
  } gbn_state_t;

  // One queued event
  typedef struct packed {
    gbn_op_t                 op;
    logic [PAYLOAD_BITS-1:0] data;
    logic [FLD_SEQ_W-1:0]    rseq;
    logic [FLD_SEQ_W-1:0]    rack;
  } gbn_item_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } gbn_qstat_t;

  // One result item
  typedef struct packed {
    gbn_kind_t               kind;
    logic [FLD_SEQ_W-1:0]    seq;
    logic [FLD_SEQ_W-1:0]    ack;
    logic [PAYLOAD_BITS-1:0] data;
    logic [FLD_SEQ_W-1:0]    outstanding;
    logic                    window_open;
    logic                    last;
  } gbn_res_t;

  // Trim a sequence-sized value to the output field
  function automatic logic [FLD_SEQ_W-1:0] fit_seq(input logic [SEQ_CAP_W-1:0] v);
    fit_seq = v[FLD_SEQ_W-1:0];
  endfunction

  // True when b lies in the circular range [a, c)
  function automatic logic circ_between(input logic [SEQ_CAP_W-1:0] a,
                                        input logic [SEQ_CAP_W-1:0] b,
                                        input logic [SEQ_CAP_W-1:0] c);
    circ_between = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                   ((b < c) && (c < a));
  endfunction

endpackage

/* rtl/gbn_front.sv */
// Front end: takes input transfers, drops checksum errors, queues the rest.
`timescale 1ns / 1ps

module gbn_front (
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // payload, rx_seq, rx_ack, rx_payload (lowest bits first), zero padded
  input  logic [gbn_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action
  input  logic [gbn_pkg::FLD_ACT_W-1:0]       in_tuser,
  input  gbn_pkg::gbn_qstat_t                 q_stat,
  output logic                                q_push,
  output gbn_pkg::gbn_item_t                  q_item
);
  import gbn_pkg::*;

  logic keep;

  // Take a transfer whenever the queue has room
  assign in_tready = !q_stat.full;

  // Classify the action and pick the payload that matters
  always_comb begin
    keep        = 1'b1;
    q_item.op   = OP_SEND;
    q_item.data = in_tdata[IN_PAY_LSB +: PAYLOAD_BITS];
    q_item.rseq = in_tdata[IN_RSEQ_LSB +: FLD_SEQ_W];
    q_item.rack = in_tdata[IN_RACK_LSB +: FLD_SEQ_W];
    unique case (in_tuser)
      ACT_SEND: begin
        q_item.op = OP_SEND;
      end
      ACT_ARRIVE: begin
        q_item.op   = OP_ARRIVE;
        q_item.data = in_tdata[IN_RPAY_LSB +: PAYLOAD_BITS];
      end
      ACT_CKSUM: begin
        // corrupted frame: nothing to do
        keep = 1'b0;
      end
      ACT_TIMEOUT: begin
        q_item.op = OP_TIMEOUT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = rst_n && in_tvalid && in_tready && keep;

endmodule

/* rtl/gbn_queue.sv */
// Short event queue between the front and back ends.
`timescale 1ns / 1ps

module gbn_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gbn_pkg::gbn_item_t  push_item,
  input  logic                pop,
  output gbn_pkg::gbn_item_t  pop_item,
  output gbn_pkg::gbn_qstat_t stat
);
  import gbn_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  gbn_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/gbn_back.sv */
// Back end: window bookkeeping, packet store, replay and result register.
`timescale 1ns / 1ps

`include "go_back_n_arq_endpoint_defines.svh"

module gbn_back #(
  parameter int MAX_SEQ_NUM = gbn_pkg::MAX_SEQ_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gbn_pkg::gbn_qstat_t q_stat,
  input  gbn_pkg::gbn_item_t  q_item,
  output logic                q_pop,
  output logic                res_tvalid,
  input  logic                res_tready,
  output gbn_pkg::gbn_res_t   res_out
);
  import gbn_pkg::*;

  localparam int SEQ_W   = $clog2(MAX_SEQ_NUM + 1);
  localparam int SEQ_MOD = MAX_SEQ_NUM + 1;

  gbn_state_t              state_r, state_nxt;
  logic [SEQ_W-1:0]        nts_r, nts_nxt;
  logic [SEQ_W-1:0]        old_r, old_nxt;
  logic [SEQ_W-1:0]        exp_r, exp_nxt;
  logic [SEQ_W-1:0]        cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]        rem_r, rem_nxt;
  logic [FLD_SEQ_W-1:0]    rseq_r, rseq_nxt;
  logic [FLD_SEQ_W-1:0]    rack_r, rack_nxt;
  logic [PAYLOAD_BITS-1:0] data_r, data_nxt;
  gbn_kind_t               kind_r, kind_nxt;

  logic [PAYLOAD_BITS-1:0] store [SEQ_MOD];
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic                    mem_we;

  logic                    out_valid_r;
  gbn_res_t                out_res_r;
  logic                    out_free;
  logic                    res_valid;
  gbn_res_t                res;

  logic [SEQ_W-1:0]        piggy;
  logic                    can_retire;
  logic                    window_full;
  logic [SEQ_W:0]          win_span;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    seq_inc = (s == SEQ_W'(MAX_SEQ_NUM)) ? '0 : s + 1'b1;
  endfunction

  function automatic gbn_res_t make_res(input gbn_kind_t               k,
                                        input logic [FLD_SEQ_W-1:0]    sq,
                                        input logic [FLD_SEQ_W-1:0]    ak,
                                        input logic [PAYLOAD_BITS-1:0] d,
                                        input logic [SEQ_W-1:0]        cnt,
                                        input logic                    lst);
    gbn_res_t r;
    r.kind        = k;
    r.seq         = sq;
    r.ack         = ak;
    r.data        = d;
    r.outstanding = fit_seq(SEQ_CAP_W'(cnt));
    r.window_open = (cnt < SEQ_W'(MAX_SEQ_NUM));
    r.last        = lst;
    make_res = r;
  endfunction

  // Result register frees up when empty or being taken
  assign out_free    = !out_valid_r || res_tready;
  assign piggy       = (exp_r == '0) ? SEQ_W'(MAX_SEQ_NUM) : exp_r - 1'b1;
  assign window_full = (cnt_r >= SEQ_W'(MAX_SEQ_NUM));
  assign can_retire  = (cnt_r != '0) &&
                       circ_between(SEQ_CAP_W'(old_r), SEQ_CAP_W'(rack_r),
                                    SEQ_CAP_W'(nts_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_item.op)
            OP_SEND:    state_nxt = ST_IDLE;
            OP_ARRIVE:  state_nxt = ST_RETIRE;
            OP_TIMEOUT: state_nxt = (cnt_r != '0) ? ST_RPL_WAIT : ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RETIRE: begin
        if (!can_retire && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RPL_WAIT: begin
        state_nxt = ST_RPL_OUT;
      end
      ST_RPL_OUT: begin
        if (out_free) begin
          state_nxt = (rem_r == SEQ_W'(1)) ? ST_IDLE : ST_RPL_WAIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    nts_nxt   = nts_r;
    old_nxt   = old_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    rseq_nxt  = rseq_r;
    rack_nxt  = rack_r;
    data_nxt  = data_r;
    kind_nxt  = kind_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    res_valid = 1'b0;
    res       = make_res(KIND_SENT, '0, '0, '0, cnt_r, 1'b1);
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_item.op)
            OP_SEND: begin
              if (out_free) begin
                q_pop     = 1'b1;
                res_valid = 1'b1;
                if (window_full) begin
                  res = make_res(KIND_REFUSED, '0, '0, '0, cnt_r, 1'b1);
                end else begin
                  mem_we  = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                  nts_nxt = seq_inc(nts_r);
                  res     = make_res(KIND_SENT, fit_seq(SEQ_CAP_W'(nts_r)),
                                     fit_seq(SEQ_CAP_W'(piggy)), q_item.data,
                                     cnt_r + 1'b1, 1'b1);
                end
              end
            end
            OP_ARRIVE: begin
              q_pop    = 1'b1;
              rseq_nxt = q_item.rseq;
              rack_nxt = q_item.rack;
              if (SEQ_CAP_W'(q_item.rseq) == SEQ_CAP_W'(exp_r)) begin
                kind_nxt = KIND_DELIVERED;
                data_nxt = q_item.data;
                exp_nxt  = seq_inc(exp_r);
              end else begin
                kind_nxt = KIND_DROPPED;
                data_nxt = '0;
              end
            end
            OP_TIMEOUT: begin
              q_pop   = 1'b1;
              nts_nxt = old_r;
              rem_nxt = cnt_r;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_RETIRE: begin
        // one frame retired per cycle, result once the ack is used up
        if (can_retire) begin
          cnt_nxt = cnt_r - 1'b1;
          old_nxt = seq_inc(old_r);
        end else if (out_free) begin
          res_valid = 1'b1;
          res       = make_res(kind_r, rseq_r, '0, data_r, cnt_r, 1'b1);
        end
      end
      ST_RPL_WAIT: begin
        // store read of the frame under nts_r lands in rd_data_r
      end
      ST_RPL_OUT: begin
        if (out_free) begin
          res_valid = 1'b1;
          res       = make_res(KIND_SENT, fit_seq(SEQ_CAP_W'(nts_r)),
                               fit_seq(SEQ_CAP_W'(piggy)), rd_data_r, cnt_r,
                               rem_r == SEQ_W'(1));
          nts_nxt   = seq_inc(nts_r);
          rem_nxt   = rem_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nts_r       <= '0;
      old_r       <= '0;
      exp_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nts_r   <= nts_nxt;
      old_r   <= old_nxt;
      exp_r   <= exp_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      if (out_free) begin
        out_valid_r <= res_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rseq_r <= rseq_nxt;
    rack_r <= rack_nxt;
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    if (out_free && res_valid) begin
      out_res_r <= res;
    end
  end

  // Packet store: written on send, read at the send cursor
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[nts_r] <= q_item.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store[nts_r];
  end

  assign res_tvalid = out_valid_r;
  assign res_out    = out_res_r;

  // Window span seen from the two cursors
  assign win_span = (nts_r >= old_r) ? ({1'b0, nts_r} - {1'b0, old_r})
                                     : ({1'b0, nts_r} + (SEQ_W + 1)'(SEQ_MOD) -
                                        {1'b0, old_r});

  `GBN_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= SEQ_W'(MAX_SEQ_NUM))
  `GBN_ASSERT_IMP(a_cnt_span, clk, rst_n, state_r == ST_IDLE || state_r == ST_RETIRE, (SEQ_W + 1)'(cnt_r) == win_span)
  `GBN_ASSERT_IMP(a_we_idle, clk, rst_n, mem_we, state_r == ST_IDLE && out_free && !window_full)
  `GBN_ASSERT_NXT(a_retire_shrinks, clk, rst_n, state_r == ST_RETIRE, cnt_r <= $past(cnt_r))

endmodule

/* rtl/go_back_n_arq_endpoint.sv */
// Go-back-N ARQ endpoint top level: front end, event queue and back end.
// A send result passes through the event queue, then the result register; an
// arrival first retires each frame its ack covers; a timeout replays frames.
// Throughput: 1 send per cycle unless out_tready stalls; the back end sequencer
// retires one frame and replays one store read per step for arrivals and replays.
// Reset (rst_n low, synchronous) clears cursors, counts, queue and result valid;
// the packet store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module go_back_n_arq_endpoint #(
  parameter int MAX_SEQ_NUM = gbn_pkg::MAX_SEQ_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // payload, rx_seq, rx_ack, rx_payload (lowest bits first), zero padded
  input  logic [gbn_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action
  input  logic [gbn_pkg::FLD_ACT_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // seq, ack, data_out, outstanding, window_open (lowest bits first), zero padded
  output logic [gbn_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // kind
  output logic [gbn_pkg::FLD_KIND_W-1:0]    out_tuser,
  output logic                              out_tlast
);
  import gbn_pkg::*;

  gbn_qstat_t q_stat;
  gbn_item_t  push_item;
  gbn_item_t  pop_item;
  logic       q_push;
  logic       q_pop;
  gbn_res_t   res;

  gbn_front u_front (
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  gbn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  gbn_back #(
    .MAX_SEQ_NUM (MAX_SEQ_NUM)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .res_tvalid (out_tvalid),
    .res_tready (out_tready),
    .res_out    (res)
  );

  // Pack the result onto the stream
  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, res.window_open,
                      res.outstanding, res.data, res.ack, res.seq};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

/* sim/arq_result_checker.sv */
// Checker for the go-back-N endpoint: predicts the frames of each event and compares them.
`timescale 1ns / 1ps

module arq_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [gbn_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [gbn_pkg::FLD_ACT_W-1:0]   in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [gbn_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [gbn_pkg::FLD_KIND_W-1:0]  out_tuser,
  input  logic                            out_tlast,
  output int                              mismatch_count,
  output int                              pending_results,
  output int                              results_checked
);
  import gbn_pkg::*;

  localparam int WINDOW = MAX_SEQ_DEF;

  // Result tdata layout, lowest bits first
  localparam int O_SEQ_LSB  = 0;
  localparam int O_ACK_LSB  = O_SEQ_LSB + FLD_SEQ_W;
  localparam int O_DATA_LSB = O_ACK_LSB + FLD_SEQ_W;
  localparam int O_OUT_LSB  = O_DATA_LSB + PAYLOAD_BITS;
  localparam int O_WIN_BIT  = O_OUT_LSB + FLD_SEQ_W;

  typedef logic [FLD_SEQ_W-1:0]    seq_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

  // Mirror of the endpoint state
  seq_t        tx_next;
  seq_t        tx_base;
  seq_t        rx_expect;
  int unsigned unacked;
  pay_t        frame_store [0:WINDOW];

  gbn_res_t    expected_frames [$];

  // x lies in the circular range [lo, hi)
  function automatic logic seq_in_window(seq_t lo, seq_t x, seq_t hi);
    seq_t off_x;
    seq_t off_hi;
    off_x  = x - lo;
    off_hi = hi - lo;
    return off_x < off_hi;
  endfunction

  // Outstanding count and window flag reflect the state after the step
  function automatic gbn_res_t make_frame(gbn_kind_t k, seq_t s, seq_t a, pay_t d,
                                          logic fin);
    gbn_res_t r;
    r.kind        = k;
    r.seq         = s;
    r.ack         = a;
    r.data        = d;
    r.outstanding = unacked[FLD_SEQ_W-1:0];
    r.window_open = (unacked < WINDOW);
    r.last        = fin;
    return r;
  endfunction

  // Work out the frames one accepted event produces
  task automatic predict_link_event(logic [FLD_ACT_W-1:0] act, pay_t pay, seq_t rseq,
                                    seq_t rack, pay_t rpay);
    int unsigned burst;
    gbn_kind_t   k;
    pay_t        d;
    seq_t        piggy;
    piggy = rx_expect - 3'd1;
    case (act)
      ACT_SEND: begin
        if (unacked >= WINDOW) begin
          expected_frames.push_back(make_frame(KIND_REFUSED, '0, '0, '0, 1'b1));
        end else begin
          frame_store[tx_next] = pay;
          unacked++;
          expected_frames.push_back(make_frame(KIND_SENT, tx_next, piggy, pay, 1'b1));
          tx_next++;
        end
      end
      ACT_ARRIVE: begin
        if (rseq == rx_expect) begin
          k = KIND_DELIVERED;
          d = rpay;
          rx_expect++;
        end else begin
          k = KIND_DROPPED;
          d = '0;
        end
        // cumulative ack retires frames from the oldest
        while (unacked > 0 && seq_in_window(tx_base, rack, tx_next)) begin
          unacked--;
          tx_base++;
        end
        expected_frames.push_back(make_frame(k, rseq, '0, d, 1'b1));
      end
      ACT_TIMEOUT: begin
        // go back to the oldest unacked frame and replay them all
        burst   = unacked;
        tx_next = tx_base;
        for (int unsigned i = 0; i < burst; i++) begin
          expected_frames.push_back(make_frame(KIND_SENT, tx_next, piggy,
                                               frame_store[tx_next], (i + 1 == burst)));
          tx_next++;
        end
      end
      default: begin
        // checksum error: nothing happens
      end
    endcase
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Watch both channels; predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    gbn_res_t want;
    if (!rst_n) begin
      tx_next         = '0;
      tx_base         = '0;
      rx_expect       = '0;
      unacked         = 0;
      mismatch_count  = 0;
      results_checked = 0;
      expected_frames.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_link_event(in_tuser,
                           in_tdata[IN_PAY_LSB +: PAYLOAD_BITS],
                           in_tdata[IN_RSEQ_LSB +: FLD_SEQ_W],
                           in_tdata[IN_RACK_LSB +: FLD_SEQ_W],
                           in_tdata[IN_RPAY_LSB +: PAYLOAD_BITS]);
      end
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (expected_frames.size() == 0) begin
          $error("result transfer with no expected result pending (kind %0d, seq %0d)",
                 out_tuser, out_tdata[O_SEQ_LSB +: FLD_SEQ_W]);
          mismatch_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("seq", want.seq, out_tdata[O_SEQ_LSB +: FLD_SEQ_W]);
          check_field("ack", want.ack, out_tdata[O_ACK_LSB +: FLD_SEQ_W]);
          check_field("data_out", want.data, out_tdata[O_DATA_LSB +: PAYLOAD_BITS]);
          check_field("outstanding", want.outstanding, out_tdata[O_OUT_LSB +: FLD_SEQ_W]);
          check_field("window_open", want.window_open, out_tdata[O_WIN_BIT]);
          check_field("last", want.last, out_tlast);
        end
      end
    end
    pending_results <= expected_frames.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the go-back-N endpoint: clock, reset, event stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import gbn_pkg::*;

  localparam int RANDOM_EVENTS = 400;
  localparam int QUIET_EVENTS  = 60;   // tail of the run with no idling
  localparam int HOLD_AT       = 150;  // events sent before the long sink hold-off
  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_LIMIT   = 3000; // cycles without any transfer
  localparam int DRAIN_CYCLES  = 40;

  typedef logic [FLD_SEQ_W-1:0]    seq_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FLD_ACT_W-1:0]   in_tuser = ACT_CKSUM;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [FLD_KIND_W-1:0]  out_tuser;
  logic                   out_tlast;

  int mismatch_count;
  int pending_results;
  int results_checked;

  // Stimulus bookkeeping
  int   events_sent = 0;
  int   sends_driven = 0;
  int   arrivals_driven = 0;
  int   cksum_driven = 0;
  int   timeouts_driven = 0;
  logic quiet = 1'b0;
  seq_t peer_seq = '0;  // next in-order sequence number the far end would send

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  go_back_n_arq_endpoint u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  arq_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results),
    .results_checked(results_checked)
  );

  // Offer one event and hold it until the transfer, then maybe idle a little
  task automatic offer_event(logic [FLD_ACT_W-1:0] act, pay_t pay, seq_t rseq, seq_t rack,
                             pay_t rpay);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, rpay, rack, rseq, pay};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sent++;
    case (act)
      ACT_SEND:    sends_driven++;
      ACT_ARRIVE:  arrivals_driven++;
      ACT_CKSUM:   cksum_driven++;
      ACT_TIMEOUT: timeouts_driven++;
      default:     ;
    endcase
    if (act == ACT_ARRIVE && rseq == peer_seq) peer_seq++;
    quiet = (events_sent >= HOLD_AT + RANDOM_EVENTS - QUIET_EVENTS - HOLD_AT + 20);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Result sink: short random stalls, one long hold-off, none at the end
  initial begin : result_sink
    int   stall_left;
    int   hold_left;
    logic hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && events_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no transfer for %0d cycles, %0d results still expected", STALL_LIMIT,
           pending_results);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int   pick;
    seq_t rseq;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty timeout, checksum error, fill the window, refusal
    offer_event(ACT_TIMEOUT, '0, '0, '0, '0);
    offer_event(ACT_CKSUM, '0, '0, '0, '0);
    offer_event(ACT_SEND, 24'h000000, '0, '0, '0);
    offer_event(ACT_SEND, 24'hFFFFFF, '0, '0, '0);
    repeat (5) offer_event(ACT_SEND, pay_t'($urandom), '0, '0, '0);
    offer_event(ACT_SEND, pay_t'($urandom), '0, '0, '0);
    // full replay of seven frames
    offer_event(ACT_TIMEOUT, '0, '0, '0, '0);
    // in order, ack outside the window; out of order, partial retire; retire the rest
    offer_event(ACT_ARRIVE, '0, 3'd0, 3'd7, 24'hFFFFFF);
    offer_event(ACT_ARRIVE, '0, 3'd5, 3'd2, pay_t'($urandom));
    offer_event(ACT_ARRIVE, '0, 3'd1, 3'd6, 24'h000000);
    // sequence numbers wrap past the modulus
    repeat (3) offer_event(ACT_SEND, pay_t'($urandom), '0, '0, '0);
    offer_event(ACT_TIMEOUT, '0, '0, '0, '0);
    offer_event(ACT_ARRIVE, '0, 3'd7, 3'd7, 24'h000000);
    offer_event(ACT_CKSUM, 24'hFFFFFF, 3'd7, 3'd7, 24'hFFFFFF);
    offer_event(ACT_ARRIVE, '0, 3'd2, 3'd1, pay_t'($urandom));
    offer_event(ACT_TIMEOUT, '0, '0, '0, '0);

    // Random traffic: sends and arrivals, arrivals mostly in order from the far end, some noise
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        offer_event(ACT_SEND, pay_t'($urandom), seq_t'($urandom), seq_t'($urandom),
                    pay_t'($urandom));
      end else if (pick < 75) begin
        rseq = ($urandom_range(0, 9) < 7) ? peer_seq : seq_t'($urandom);
        offer_event(ACT_ARRIVE, pay_t'($urandom), rseq, seq_t'($urandom),
                    pay_t'($urandom));
      end else if (pick < 85) begin
        offer_event(ACT_CKSUM, pay_t'($urandom), seq_t'($urandom), seq_t'($urandom),
                    pay_t'($urandom));
      end else begin
        offer_event(ACT_TIMEOUT, pay_t'($urandom), seq_t'($urandom), seq_t'($urandom),
                    pay_t'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then allow time for any stray result
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d events: %0d sends, %0d arrivals, %0d checksum errors, %0d timeouts",
             events_sent, sends_driven, arrivals_driven, cksum_driven, timeouts_driven);
    $display("Checked %0d result transfers across a %0d-cycle sink hold-off",
             results_checked, HOLD_CYCLES);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
